@@ design/stse_pkg.sv @@
// Package with the request item type, action and status codes of the sorted token set engine.
`timescale 1ns / 1ps

package stse_pkg;

   localparam logic [1:0] ACT_SEARCH = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_MASK   = 2'd3;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_EXISTS    = 3'd1;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_NONE      = 3'd4;

   localparam int TOKEN_W = 32;
   localparam int LIB_W   = 4;
   localparam int COUNT_W = 6;

   typedef struct packed {
      logic [1:0]          action;
      logic [TOKEN_W-1:0]  token;
      logic [TOKEN_W-1:0]  mask;
      logic [TOKEN_W-1:0]  value;
   } req_item_type;

endpackage

@@ design/sorted_token_set_engine.sv @@
// Top level of the sorted token set engine: configuration register, front end and back end.
// Search and mask-out read and evaluate every stored token in turn; insert and remove then
// shift the entries after the insert or remove position one by one. The back end takes
// one request at a time through its memory read and evaluate loop; the front queue holds
// two more requests.
// Reset clears the count and the queue; library enables reset to all ones.
`timescale 1ns / 1ps

module sorted_token_set_engine #(
   parameter int CAPACITY      = 32,
   parameter int LIBRARY_SHIFT = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_token_in,
   input  logic [31:0] req_match_mask,
   input  logic [31:0] req_match_value,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_token_out,
   output logic [5:0]  rsp_entry_count,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   stse_pkg::req_item_type item;
   logic        item_valid;
   logic        item_pop;
   logic [15:0] lib_enable_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {16'd0, lib_enable_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lib_enable_ff <= 16'hFFFF;
      end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         lib_enable_ff <= pwdata[15:0];
      end
   end

   stse_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_token_in    (req_token_in),
      .req_match_mask  (req_match_mask),
      .req_match_value (req_match_value),
      .item            (item),
      .item_valid      (item_valid),
      .item_pop        (item_pop)
   );

   stse_back #(
      .CAPACITY      (CAPACITY),
      .LIBRARY_SHIFT (LIBRARY_SHIFT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item            (item),
      .item_valid      (item_valid),
      .item_pop        (item_pop),
      .lib_enable      (lib_enable_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_token_out   (rsp_token_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule

@@ design/stse_front.sv @@
// Front end: accepts requests and holds them in a two-entry queue for the back end.
`timescale 1ns / 1ps

module stse_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_action,
   input  logic [31:0]            req_token_in,
   input  logic [31:0]            req_match_mask,
   input  logic [31:0]            req_match_value,
   output stse_pkg::req_item_type item,
   output logic                   item_valid,
   input  logic                   item_pop
);

   stse_pkg::req_item_type slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   assign busy       = (fill_ff == 2'd2);
   assign push       = start && !busy;
   assign item_valid = (fill_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{action: req_action, token: req_token_in,
                                 mask: req_match_mask, value: req_match_value};
      end
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'd2) else $error("queue fill out of range");
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> fill_ff == $past(fill_ff) + 2'd1) else $error("queue push lost");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd1) |-> (rd_ptr_ff != wr_ptr_ff)) else $error("queue pointers disagree");
`endif

endmodule

@@ design/stse_back.sv @@
// Back end: sorted token store and the sequencer that searches, inserts, removes and compacts.
`timescale 1ns / 1ps

module stse_back #(
   parameter int CAPACITY      = 32,
   parameter int LIBRARY_SHIFT = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stse_pkg::req_item_type item,
   input  logic                   item_valid,
   output logic                   item_pop,
   input  logic [15:0]            lib_enable,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_token_out,
   output logic [5:0]             rsp_entry_count,
   output logic                   rsp_last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RD    = 8'b0000_0010,
      ST_EV    = 8'b0000_0100,
      ST_IS_RD = 8'b0000_1000,
      ST_IS_WR = 8'b0001_0000,
      ST_RS_RD = 8'b0010_0000,
      ST_RS_WR = 8'b0100_0000
   } state_type;

   logic [31:0] mem [CAPACITY];

   state_type              state_ff, state_in;
   stse_pkg::req_item_type op_ff, op_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          wr_ff, wr_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [31:0]            pend_ff, pend_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [31:0]            rdata_ff;
   logic                   rsp_strobe_ff;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_token_ff, rsp_token_in;
   logic [5:0]             rsp_count_ff;
   logic                   rsp_last_ff, rsp_last_in;

   logic          emit;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [CW-1:0] idx_inc;
   logic [CW-1:0] idx_dec;
   logic          full;
   logic          keep;
   logic          enabled;

   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);
   assign full    = (count_ff >= CW'(CAPACITY));
   assign keep    = ((rdata_ff & op_ff.mask) != op_ff.value);
   assign enabled = lib_enable[rdata_ff[LIBRARY_SHIFT +: stse_pkg::LIB_W]];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      item_pop      = 1'b0;
      emit          = 1'b0;
      rsp_status_in = stse_pkg::STAT_OK;
      rsp_token_in  = '0;
      rsp_last_in   = 1'b1;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff[AW-1:0];
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = rdata_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop      = 1'b1;
               op_in         = item;
               idx_in        = '0;
               wr_in         = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_RD;
            end
         end
         ST_RD: begin
            if (idx_ff < count_ff) begin
               mem_re   = 1'b1;
               state_in = ST_EV;
            end else begin
               state_in = ST_IDLE;
               case (op_ff.action)
                  stse_pkg::ACT_SEARCH: begin
                     emit = 1'b1;
                     if (pend_valid_ff) begin
                        rsp_token_in = pend_ff;
                     end else begin
                        rsp_status_in = stse_pkg::STAT_NONE;
                     end
                  end
                  stse_pkg::ACT_INSERT: begin
                     if (full) begin
                        emit          = 1'b1;
                        rsp_status_in = stse_pkg::STAT_FULL;
                     end else begin
                        pos_in   = idx_ff;
                        state_in = ST_IS_RD;
                     end
                  end
                  stse_pkg::ACT_REMOVE: begin
                     emit          = 1'b1;
                     rsp_status_in = stse_pkg::STAT_NOT_FOUND;
                  end
                  default: begin
                     emit     = 1'b1;
                     count_in = wr_ff;
                  end
               endcase
            end
         end
         ST_EV: begin
            state_in = ST_RD;
            idx_in   = idx_inc;
            case (op_ff.action)
               stse_pkg::ACT_SEARCH: begin
                  if (enabled) begin
                     if (pend_valid_ff) begin
                        emit         = 1'b1;
                        rsp_token_in = pend_ff;
                        rsp_last_in  = 1'b0;
                     end
                     pend_in       = rdata_ff;
                     pend_valid_in = 1'b1;
                  end
               end
               stse_pkg::ACT_INSERT: begin
                  if (rdata_ff == op_ff.token) begin
                     emit          = 1'b1;
                     rsp_status_in = stse_pkg::STAT_EXISTS;
                     state_in      = ST_IDLE;
                  end else if (rdata_ff > op_ff.token) begin
                     if (full) begin
                        emit          = 1'b1;
                        rsp_status_in = stse_pkg::STAT_FULL;
                        state_in      = ST_IDLE;
                     end else begin
                        pos_in   = idx_ff;
                        idx_in   = count_ff;
                        state_in = ST_IS_RD;
                     end
                  end
               end
               stse_pkg::ACT_REMOVE: begin
                  if (rdata_ff == op_ff.token) begin
                     idx_in   = idx_ff;
                     state_in = ST_RS_RD;
                  end
               end
               default: begin
                  if (keep) begin
                     mem_we    = 1'b1;
                     mem_waddr = wr_ff[AW-1:0];
                     wr_in     = wr_ff + CW'(1);
                  end
               end
            endcase
         end
         ST_IS_RD: begin
            if (idx_ff > pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_dec[AW-1:0];
               state_in  = ST_IS_WR;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[AW-1:0];
               mem_wdata = op_ff.token;
               count_in  = count_ff + CW'(1);
               emit      = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_IS_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_dec;
            state_in = ST_IS_RD;
         end
         ST_RS_RD: begin
            if (idx_inc < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_inc[AW-1:0];
               state_in  = ST_RS_WR;
            end else begin
               count_in = count_ff - CW'(1);
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RS_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_inc;
            state_in = ST_RS_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
      wr_ff  <= wr_in;
      pos_ff <= pos_in;
      pend_ff <= pend_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_token_ff  <= rsp_token_in;
         rsp_count_ff  <= 6'(count_in);
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_token_out   = rsp_token_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("stored count exceeds capacity");
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff != ST_IDLE)) else $error("result without a request");
   a_token_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != stse_pkg::STAT_OK) |-> rsp_token_out == '0)
      else $error("error result carries a token");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> state_ff == ST_IDLE) else $error("request taken while busy");
`endif

endmodule

@@ dv/tb_sorted_token_set_engine.sv @@
// Self-checking testbench for the sorted token set engine with its own set predictor.
`timescale 1ns / 1ps

module tb_sorted_token_set_engine;

   localparam int CAP = 32;
   localparam int LSHIFT = 24;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] token;
      logic [5:0]  count;
      logic        last;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [31:0] req_token_in = '0;
   logic [31:0] req_match_mask = '0;
   logic [31:0] req_match_value = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_token_out;
   logic [5:0]  rsp_entry_count;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   sorted_token_set_engine dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Predicted contents of the set and the library enables.
   logic [31:0] set_tokens[$];
   logic [15:0] lib_enables;
   rsp_item_type expected_rsps[$];
   stse_pkg::req_item_type pending_reqs[$];
   logic [31:0] set_like_pool[$];
   int error_count = 0;
   int rsp_seen = 0;
   int req_sent = 0;
   longint cycle_count = 0;
   bit quiet_phase = 1'b0;
   bit hold_off = 1'b0;
   logic accepted_last = 1'b0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic void predict_request(input stse_pkg::req_item_type r);
      int pos;
      int found;
      logic [31:0] kept[$];
      logic [2:0] st;
      st = stse_pkg::STAT_OK;
      case (r.action)
         stse_pkg::ACT_SEARCH: begin
            found = 0;
            foreach (set_tokens[i]) begin
               if (lib_enables[set_tokens[i][LSHIFT +: 4]]) begin
                  expected_rsps.push_back({stse_pkg::STAT_OK, set_tokens[i],
                                           6'(set_tokens.size()), 1'b0});
                  found++;
               end
            end
            if (found == 0)
               expected_rsps.push_back({stse_pkg::STAT_NONE, 32'd0,
                                        6'(set_tokens.size()), 1'b1});
            else
               expected_rsps[$].last = 1'b1;
            return;
         end
         stse_pkg::ACT_INSERT: begin
            pos = 0;
            while (pos < set_tokens.size() && set_tokens[pos] < r.token) pos++;
            if (pos < set_tokens.size() && set_tokens[pos] == r.token)
               st = stse_pkg::STAT_EXISTS;
            else if (set_tokens.size() >= CAP) st = stse_pkg::STAT_FULL;
            else set_tokens.insert(pos, r.token);
         end
         stse_pkg::ACT_REMOVE: begin
            pos = -1;
            foreach (set_tokens[i]) if (set_tokens[i] == r.token) pos = i;
            if (pos < 0) st = stse_pkg::STAT_NOT_FOUND;
            else set_tokens.delete(pos);
         end
         default: begin
            foreach (set_tokens[i])
               if ((set_tokens[i] & r.mask) != r.value) kept.push_back(set_tokens[i]);
            set_tokens = kept;
         end
      endcase
      expected_rsps.push_back({st, 32'd0, 6'(set_tokens.size()), 1'b1});
   endfunction

   // Driver: presents queued requests at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || accepted_last) begin
            if (pending_reqs.size() > 0 && !hold_off &&
                (quiet_phase || $urandom_range(99) >= 8)) begin
               req_action <= pending_reqs[0].action;
               req_token_in <= pending_reqs[0].token;
               req_match_mask <= pending_reqs[0].mask;
               req_match_value <= pending_reqs[0].value;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Acceptance and result monitor at the rising edge.
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type exp;
      cycle_count++;
      accepted_last <= 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            predict_request(pending_reqs[0]);
            void'(pending_reqs.pop_front());
            req_sent++;
            accepted_last <= 1'b1;
         end
         if (rsp_strobe) begin
            got = {rsp_status, rsp_token_out, rsp_entry_count, rsp_last};
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", got));
            end else begin
               exp = expected_rsps.pop_front();
               if (got.status !== exp.status)
                  report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
               if (got.token !== exp.token)
                  report_mismatch($sformatf("token %h, expected %h", got.token, exp.token));
               if (got.count !== exp.count)
                  report_mismatch($sformatf("count %0d, expected %0d", got.count, exp.count));
               if (got.last !== exp.last)
                  report_mismatch($sformatf("last %b, expected %b", got.last, exp.last));
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("sorted_token_set_engine regression: fail");
         $finish;
      end
   end

   function automatic logic [31:0] pick_token();
      logic [31:0] t;
      case ($urandom_range(3))
         0: t = {4'($urandom_range(15)), 4'($urandom_range(3)), 20'd0, 4'($urandom_range(15))};
         1: t = (set_like_pool.size() > 0) ?
               set_like_pool[$urandom_range(set_like_pool.size() - 1)] : $urandom();
         default: t = $urandom();
      endcase
      set_like_pool.push_back(t);
      if (set_like_pool.size() > 64) void'(set_like_pool.pop_front());
      return t;
   endfunction

   task automatic queue_req(input logic [1:0] a, input logic [31:0] t,
                            input logic [31:0] m, input logic [31:0] v);
      pending_reqs.push_back({a, t, m, v});
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(input logic [15:0] val);
      logic [31:0] rd;
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'($urandom()), val};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
      psel <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
      lib_enables = val;
      if (rd[15:0] !== val) report_mismatch($sformatf("enable readback %h", rd));
   endtask

   task automatic random_phase(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40) queue_req(stse_pkg::ACT_INSERT, pick_token(), $urandom(), $urandom());
         else if (r < 65)
            queue_req(stse_pkg::ACT_REMOVE, pick_token(), $urandom(), $urandom());
         else if (r < 85)
            queue_req(stse_pkg::ACT_SEARCH, $urandom(), $urandom(), $urandom());
         else queue_req(stse_pkg::ACT_MASK, $urandom(),
                        {4'hF, 28'd0} | ($urandom_range(1) ? 32'hF : 32'h0),
                        {4'($urandom_range(15)), 28'd0} | $urandom_range(15));
      end
   endtask

   initial begin
      lib_enables = 16'hFFFF;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: extremes, duplicates, misses, masks and empty searches.
      queue_req(stse_pkg::ACT_SEARCH, 32'd0, 32'd0, 32'd0);
      queue_req(stse_pkg::ACT_REMOVE, 32'h0, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_INSERT, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(stse_pkg::ACT_INSERT, 32'h0, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_INSERT, 32'h0300_0001, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_INSERT, 32'hF500_0002, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_REMOVE, 32'h1234_5678, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_REMOVE, 32'h0, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_MASK, 32'h0, 32'h0000_0003, 32'h0000_0005);
      queue_req(stse_pkg::ACT_MASK, 32'h0, 32'h0F00_0000, 32'h0300_0000);
      queue_req(stse_pkg::ACT_SEARCH, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < 33; i++)
         queue_req(stse_pkg::ACT_INSERT, 32'h1000_0000 + i * 32'h0110_0001, 0, 0);
      queue_req(stse_pkg::ACT_INSERT, 32'h1000_0000, 0, 0);
      queue_req(stse_pkg::ACT_SEARCH, 0, 0, 0);
      queue_req(stse_pkg::ACT_MASK, 0, 32'h0, 32'h0);
      queue_req(stse_pkg::ACT_SEARCH, 0, 0, 0);
      drain();
      csr_write(16'h0000);
      queue_req(stse_pkg::ACT_INSERT, 32'h0700_0007, 0, 0);
      queue_req(stse_pkg::ACT_SEARCH, 0, 0, 0);
      drain();
      csr_write(16'h0080);
      queue_req(stse_pkg::ACT_SEARCH, 0, 0, 0);
      quiet_phase = 1'b1;
      random_phase(100);
      drain();
      quiet_phase = 1'b0;
      csr_write(16'hFFFF);
      random_phase(120);
      // Hold the sender part way through until every expected result has arrived.
      while (pending_reqs.size() > 60) @(posedge clock);
      hold_off = 1'b1;
      while (expected_rsps.size() > 0 || start) @(negedge clock);
      hold_off = 1'b0;
      drain();
      csr_write(16'($urandom()));
      random_phase(150);
      drain();
      $display("Sent %0d requests and checked %0d results across four enable settings.",
               req_sent, rsp_seen);
      if (error_count == 0)
         $display("sorted_token_set_engine regression: pass");
      else
         $display("sorted_token_set_engine regression: fail");
      $finish;
   end

endmodule
